// ===== hdl/mrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrc_pkg: shared types and helpers for the Modbus RTU reply checker
// Function codes, status codes, queue entry and configuration structures,
// and the byte-wise CRC-16 helper used by the back end.
// ----------------------------------------------------------------------------
package mrc_pkg;

  // History of final status per job slot.
  localparam int unsigned JOB_SLOTS = 8;
  localparam int unsigned SLOT_W    = $clog2(JOB_SLOTS);

  // Bytes beyond this count are dropped from a frame.
  localparam logic [7:0] MAX_FRAME = 8'd255;

  // Shortest frames that can be judged at all, and for write echoes.
  localparam logic [7:0] MIN_FRAME      = 8'd5;
  localparam logic [7:0] MIN_ECHO_FRAME = 8'd6;

  // Positions of the header bytes within a frame.
  localparam logic [7:0] POS_ADDRESS  = 8'd0;
  localparam logic [7:0] POS_FUNCTION = 8'd1;
  localparam logic [7:0] POS_COUNT    = 8'd2;
  localparam logic [7:0] POS_DATA     = 8'd3;
  localparam logic [7:0] POS_ECHO_END = 8'd5;

  // CRC-16 in its reflected form.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Exception replies set the top bit of the function code.
  localparam logic [7:0] FN_MASK = 8'h7F;

  // Function codes.
  localparam logic [7:0] FN_READ_COILS       = 8'h01;
  localparam logic [7:0] FN_READ_DISCRETE    = 8'h02;
  localparam logic [7:0] FN_READ_HOLDING     = 8'h03;
  localparam logic [7:0] FN_READ_INPUT       = 8'h04;
  localparam logic [7:0] FN_WRITE_COIL       = 8'h05;
  localparam logic [7:0] FN_WRITE_REG        = 8'h06;
  localparam logic [7:0] FN_READ_EXC_STATUS  = 8'h07;
  localparam logic [7:0] FN_WRITE_COILS      = 8'h0F;
  localparam logic [7:0] FN_WRITE_REGS       = 8'h10;
  localparam logic [7:0] FN_READ_WRITE_REGS  = 8'h17;

  // Queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_SLAVE      = 3'd0,
    REG_FUNCTION   = 3'd1,
    REG_WORDS      = 3'd2,
    REG_ECHO_ADDR  = 3'd3,
    REG_ECHO_VALUE = 3'd4,
    REG_JOB_SLOT   = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_BAD   = 3'd2,
    ST_CRC   = 3'd3,
    ST_EXC   = 3'd4
  } status_e;

  // Kind of work handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_BYTE      = 2'd0,
    OP_END_BYTE  = 2'd1,
    OP_END_EMPTY = 2'd2
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [7:0] pos;
  } entry_t;

  typedef struct packed {
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [6:0]  words;
    logic [15:0] echo_addr;
    logic [15:0] echo_value;
    logic [2:0]  job_slot;
  } cfg_t;

  // One byte through the CRC, all eight shift steps in one go.
  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic is_read_fn(input logic [7:0] f);
    return (f == FN_READ_COILS) || (f == FN_READ_DISCRETE) || (f == FN_READ_HOLDING) ||
           (f == FN_READ_INPUT) || (f == FN_READ_WRITE_REGS);
  endfunction

  function automatic logic is_write_fn(input logic [7:0] f);
    return (f == FN_WRITE_COIL) || (f == FN_WRITE_REG) || (f == FN_WRITE_COILS) ||
           (f == FN_WRITE_REGS);
  endfunction

  // Expected echo byte for frame positions two to five, by the low two bits.
  function automatic logic [7:0] echo_byte(input logic [1:0] idx, input cfg_t cfg);
    logic [7:0] r;
    case (idx)
      2'd2:    r = cfg.echo_addr[15:8];
      2'd3:    r = cfg.echo_addr[7:0];
      2'd0:    r = cfg.echo_value[15:8];
      default: r = cfg.echo_value[7:0];
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/modbus_rtu_response_checker_core.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_core: Modbus RTU master reply checker
// Checks one received reply frame byte by byte and reports its final status.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one word per received byte (rx_byte_i with
//   byte_present_i high); frame_end_i marks the last word of a frame, and an
//   end word without a byte signals a timeout. Words with neither flag are
//   consumed and ignored. The output channel returns payload bytes of read
//   replies as they arrive (kind 0) and one status word per frame (kind 1).
//   Payload bytes are only good if the frame's status turns out ok.
//   A result passes the queue and then the output register once its input
//   word is accepted; one input word is taken per cycle while the queue has
//   room, and the CRC byte update and status decision are combinational.
//   A two-word queue sits between the input front end and the checking back
//   end, so when the receiver stalls the back end keeps its result in the
//   output register and input words are still taken until the queue fills.
//   Reset returns all registers to their defaults and clears the status
//   history of every job slot. Registers are to be written over the APB port
//   only while no frame is in progress; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          byte_present_i,
  input  logic                          frame_end_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          kind_o,
  output logic [7:0]                    payload_byte_o,
  output logic [7:0]                    payload_offset_o,
  output logic [2:0]                    status_o,
  output logic [3:0]                    exception_code_o,
  output logic                          status_changed_o,
  output logic [7:0]                    frame_length_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrc_pkg::PADDR_W-1:0]   paddr,
  input  logic [mrc_pkg::PDATA_W-1:0]   pwdata,
  output logic [mrc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import mrc_pkg::*;

  cfg_t   cfg;
  entry_t push_entry, head;
  logic   push, pop, q_full, q_empty;

  // Register file.
  mrc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input front end.
  mrc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .byte_present_i (byte_present_i),
    .frame_end_i    (frame_end_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_entry_o   (push_entry)
  );

  // Queue between the two halves.
  mrc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  // Checking back end.
  mrc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .head_i           (head),
    .empty_i          (q_empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .payload_offset_o (payload_offset_o),
    .status_o         (status_o),
    .exception_code_o (exception_code_o),
    .status_changed_o (status_changed_o),
    .frame_length_o   (frame_length_o)
  );

endmodule

// ===== hdl/mrc_regs.sv =====
// ----------------------------------------------------------------------------
// mrc_regs: configuration registers
// APB-style register file holding the expected reply parameters.
// ----------------------------------------------------------------------------
module mrc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrc_pkg::PADDR_W-1:0]   paddr,
  input  logic [mrc_pkg::PDATA_W-1:0]   pwdata,
  output logic [mrc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output mrc_pkg::cfg_t                 cfg_o
);
  import mrc_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave      <= 8'd1;
      cfg_q.func       <= FN_READ_HOLDING;
      cfg_q.words      <= 7'd1;
      cfg_q.echo_addr  <= 16'h0000;
      cfg_q.echo_value <= 16'h0000;
      cfg_q.job_slot   <= 3'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SLAVE:      cfg_q.slave      <= pwdata[7:0];
        REG_FUNCTION:   cfg_q.func       <= pwdata[7:0];
        REG_WORDS:      cfg_q.words      <= pwdata[6:0];
        REG_ECHO_ADDR:  cfg_q.echo_addr  <= pwdata[15:0];
        REG_ECHO_VALUE: cfg_q.echo_value <= pwdata[15:0];
        REG_JOB_SLOT:   cfg_q.job_slot   <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      REG_SLAVE:      prdata = {24'h0, cfg_q.slave};
      REG_FUNCTION:   prdata = {24'h0, cfg_q.func};
      REG_WORDS:      prdata = {25'h0, cfg_q.words};
      REG_ECHO_ADDR:  prdata = {16'h0, cfg_q.echo_addr};
      REG_ECHO_VALUE: prdata = {16'h0, cfg_q.echo_value};
      REG_JOB_SLOT:   prdata = {29'h0, cfg_q.job_slot};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/mrc_front.sv =====
// ----------------------------------------------------------------------------
// mrc_front: input front end
// Accepts input words, tracks the position within the frame, drops idle and
// overlong bytes, and tags each remaining word for the back end.
// ----------------------------------------------------------------------------
module mrc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      rx_byte_i,
  input  logic            byte_present_i,
  input  logic            frame_end_i,
  input  logic            q_full_i,
  output logic            push_o,
  output mrc_pkg::entry_t push_entry_o
);
  import mrc_pkg::*;

  logic [7:0] pos_q, pos_d;
  logic       accept;
  logic       take_byte;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign take_byte  = byte_present_i && (pos_q < MAX_FRAME);

  // Classify the word; idle words and bytes past the frame limit go nowhere.
  always_comb begin
    push_o            = accept && (frame_end_i || take_byte);
    push_entry_o.data = rx_byte_i;
    push_entry_o.pos  = pos_q;
    if (frame_end_i) begin
      push_entry_o.op = take_byte ? OP_END_BYTE : OP_END_EMPTY;
    end else begin
      push_entry_o.op = OP_BYTE;
    end
  end

  // Frame position counter.
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (frame_end_i) begin
        pos_d = 8'd0;
      end else if (take_byte) begin
        pos_d = pos_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 8'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== hdl/mrc_queue.sv =====
// ----------------------------------------------------------------------------
// mrc_queue: short queue between front and back end
// A small FIFO of tagged words so that either side can stall on its own.
// ----------------------------------------------------------------------------
module mrc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mrc_pkg::entry_t push_entry_i,
  input  logic            pop_i,
  output mrc_pkg::entry_t head_o,
  output logic            full_o,
  output logic            empty_o
);
  import mrc_pkg::*;

  entry_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/mrc_back.sv =====
// ----------------------------------------------------------------------------
// mrc_back: frame checking back end
// Runs the CRC and the header capture on each byte, forwards payload bytes,
// and judges the frame at its end word. Results leave through a register.
// ----------------------------------------------------------------------------
module mrc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mrc_pkg::cfg_t   cfg_i,
  input  mrc_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            kind_o,
  output logic [7:0]      payload_byte_o,
  output logic [7:0]      payload_offset_o,
  output logic [2:0]      status_o,
  output logic [3:0]      exception_code_o,
  output logic            status_changed_o,
  output logic [7:0]      frame_length_o
);
  import mrc_pkg::*;

  // Frame state.
  logic [15:0] crc_q, lag0_q, lag1_q;
  logic [7:0]  tail0_q, tail1_q;
  logic [7:0]  seen_addr_q, seen_fn_q, seen_cnt_q;
  logic        echo_mis_q;
  logic [6:0]  hist_q [JOB_SLOTS];

  // State after the current word's byte.
  logic [15:0] crc_d, lag0_d, lag1_d;
  logic [7:0]  tail0_d, tail1_d;
  logic [7:0]  seen_addr_d, seen_fn_d, seen_cnt_d;
  logic        echo_mis_d;

  // Output register.
  logic        out_valid_q;
  logic        kind_q;
  logic [7:0]  pay_byte_q, pay_off_q, frame_len_q;
  status_e     status_q;
  logic [3:0]  exc_code_q;
  logic        changed_q;

  logic              ready, is_byte, is_end, emit_pay, result;
  logic [7:0]        pos, b, ef, len, pay_off;
  logic [15:0]       chk_crc;
  status_e           st;
  logic [3:0]        code;
  logic [6:0]        stored;
  logic [SLOT_W-1:0] slot;

  assign ready   = !out_valid_q || !out_stall_i;
  assign pop_o   = !empty_i && ready;
  assign is_byte = (head_i.op == OP_BYTE) || (head_i.op == OP_END_BYTE);
  assign is_end  = (head_i.op == OP_END_BYTE) || (head_i.op == OP_END_EMPTY);
  assign pos     = head_i.pos;
  assign b       = head_i.data;
  assign ef      = cfg_i.func;
  assign slot    = cfg_i.job_slot[SLOT_W-1:0];

  // Byte update of the running state.
  always_comb begin
    crc_d       = crc_q;
    lag0_d      = lag0_q;
    lag1_d      = lag1_q;
    tail0_d     = tail0_q;
    tail1_d     = tail1_q;
    seen_addr_d = seen_addr_q;
    seen_fn_d   = seen_fn_q;
    seen_cnt_d  = seen_cnt_q;
    echo_mis_d  = echo_mis_q;
    if (is_byte) begin
      crc_d   = crc_feed(crc_q, b);
      lag0_d  = crc_q;
      lag1_d  = lag0_q;
      tail0_d = b;
      tail1_d = tail0_q;
      if (pos == POS_ADDRESS) begin
        seen_addr_d = b;
      end
      if (pos == POS_FUNCTION) begin
        seen_fn_d = b;
      end
      if (pos == POS_COUNT) begin
        seen_cnt_d = b;
      end
      if ((pos >= POS_COUNT) && (pos <= POS_ECHO_END) && (b != echo_byte(pos[1:0], cfg_i))) begin
        echo_mis_d = 1'b1;
      end
    end
  end

  // Payload forwarding for read replies and the exception status reply.
  always_comb begin
    emit_pay = 1'b0;
    pay_off  = 8'd0;
    if ((head_i.op == OP_BYTE) && (pos >= POS_COUNT) && (seen_fn_q == ef)) begin
      if (is_read_fn(ef) && (pos >= POS_DATA) && ((pos - POS_DATA) < seen_cnt_q)) begin
        emit_pay = 1'b1;
        pay_off  = pos - POS_DATA;
      end else if ((ef == FN_READ_EXC_STATUS) && (pos == POS_COUNT)) begin
        emit_pay = 1'b1;
      end
    end
  end

  // Final judgement of the frame, on the state that includes the end byte.
  always_comb begin
    len     = is_byte ? (pos + 8'd1) : pos;
    chk_crc = lag1_d;
    code    = 4'd0;
    if (len < MIN_FRAME) begin
      st = ST_SHORT;
    end else if (seen_addr_d != cfg_i.slave) begin
      st = ST_BAD;
    end else if ((tail0_d != chk_crc[15:8]) || (tail1_d != chk_crc[7:0])) begin
      st = ST_CRC;
    end else if (seen_fn_d != ef) begin
      if ((seen_fn_d & FN_MASK) == ef) begin
        st   = ST_EXC;
        code = seen_cnt_d[3:0];
      end else begin
        st = ST_BAD;
      end
    end else if (is_read_fn(ef)) begin
      st = ({1'b0, seen_cnt_d[7:1]} != {1'b0, cfg_i.words}) ? ST_BAD : ST_OK;
    end else if (is_write_fn(ef)) begin
      st = (echo_mis_d || (len < MIN_ECHO_FRAME)) ? ST_BAD : ST_OK;
    end else if (ef == FN_READ_EXC_STATUS) begin
      st = ST_OK;
    end else begin
      st = ST_BAD;
    end
    stored = {st, code};
  end

  assign result = is_end || emit_pay;

  // Frame state and status history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_INIT;
      lag0_q      <= CRC_INIT;
      lag1_q      <= CRC_INIT;
      tail0_q     <= 8'd0;
      tail1_q     <= 8'd0;
      seen_addr_q <= 8'd0;
      seen_fn_q   <= 8'd0;
      seen_cnt_q  <= 8'd0;
      echo_mis_q  <= 1'b0;
      for (int k = 0; k < JOB_SLOTS; k++) begin
        hist_q[k] <= 7'd0;
      end
    end else if (pop_o) begin
      if (is_end) begin
        crc_q        <= CRC_INIT;
        lag0_q       <= CRC_INIT;
        lag1_q       <= CRC_INIT;
        tail0_q      <= 8'd0;
        tail1_q      <= 8'd0;
        seen_addr_q  <= 8'd0;
        seen_fn_q    <= 8'd0;
        seen_cnt_q   <= 8'd0;
        echo_mis_q   <= 1'b0;
        hist_q[slot] <= stored;
      end else begin
        crc_q       <= crc_d;
        lag0_q      <= lag0_d;
        lag1_q      <= lag1_d;
        tail0_q     <= tail0_d;
        tail1_q     <= tail1_d;
        seen_addr_q <= seen_addr_d;
        seen_fn_q   <= seen_fn_d;
        seen_cnt_q  <= seen_cnt_d;
        echo_mis_q  <= echo_mis_d;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready) begin
      out_valid_q <= pop_o && result;
    end
  end

  // Output word.
  always_ff @(posedge clk_i) begin
    if (pop_o && result) begin
      kind_q      <= is_end;
      pay_byte_q  <= is_end ? 8'd0 : b;
      pay_off_q   <= is_end ? 8'd0 : pay_off;
      status_q    <= is_end ? st : ST_OK;
      exc_code_q  <= is_end ? code : 4'd0;
      changed_q   <= is_end && (hist_q[slot] != stored);
      frame_len_q <= len;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign payload_byte_o   = pay_byte_q;
  assign payload_offset_o = pay_off_q;
  assign status_o         = status_q;
  assign exception_code_o = exc_code_q;
  assign status_changed_o = changed_q;
  assign frame_length_o   = frame_len_q;

  // A frame end always clears the running frame state.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_end) |=> (crc_q == CRC_INIT) && (lag1_q == CRC_INIT) && (seen_fn_q == 8'd0))
    else $error("frame state not cleared after frame end");

  // A frame end always produces a status word on the next cycle.
  a_end_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_end) |=> (out_valid_q && kind_q))
    else $error("frame end did not produce a status word");

  // Payload words carry a clean status.
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !kind_q) |-> ((status_q == ST_OK) && !changed_q && (exc_code_q == 4'd0)))
    else $error("payload word carries status");

  // Exception codes appear only with exception status.
  a_code_only_exc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q && (status_q != ST_EXC)) |-> (exc_code_q == 4'd0))
    else $error("exception code without exception status");

endmodule

// ===== sim/tb_modbus_rtu_response_checker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_response_checker_core: self-checking bench for the reply checker
// Feeds Modbus RTU reply frames, both well formed and broken, into the block
// under random idling and stalling on both channels. A scoreboard class
// predicts every payload word and frame status word and compares each
// returned word field by field. The registers are rewritten over the APB
// port between batches of frames.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_response_checker_core;
  import mrc_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned PHASE_WORDS  = 630;
  localparam int unsigned WATCHDOG_NS  = 5_000_000;
  localparam logic [15:0] CRC_START    = 16'hFFFF;
  localparam logic [15:0] CRC_REV_POLY = 16'hA001;
  localparam logic        KIND_PAYLOAD = 1'b0;
  localparam logic        KIND_STATUS  = 1'b1;

  // One input word as offered to the block.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } rx_word_t;

  // One output word, in port order.
  typedef struct packed {
    logic       kind;
    logic [7:0] pbyte;
    logic [7:0] offset;
    logic [2:0] status;
    logic [3:0] code;
    logic       changed;
    logic [7:0] length;
  } reply_word_t;

  // Scoreboard: follows the frame state and queues the words the block owes.
  class frame_scoreboard;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [6:0]  words;
    logic [15:0] echo_addr;
    logic [15:0] echo_val;
    logic [2:0]  slot;

    logic [15:0] crc_run;
    logic [15:0] crc_one_back;
    logic [15:0] crc_two_back;
    logic [7:0]  nbytes;
    logic [7:0]  tail_last;
    logic [7:0]  tail_prev;
    logic [7:0]  hdr_addr;
    logic [7:0]  hdr_fn;
    logic [7:0]  hdr_cnt;
    logic        echo_bad;
    logic [6:0]  hist [JOB_SLOTS];

    reply_word_t due_replies[$];
    int unsigned errors;
    int unsigned nchecked;

    function new();
      slave     = 8'd1;
      func      = FN_READ_HOLDING;
      words     = 7'd1;
      echo_addr = 16'h0000;
      echo_val  = 16'h0000;
      slot      = 3'd0;
      errors    = 0;
      nchecked  = 0;
      foreach (hist[i]) hist[i] = 7'd0;
      clear_frame();
    endfunction

    function void clear_frame();
      crc_run      = CRC_START;
      crc_one_back = CRC_START;
      crc_two_back = CRC_START;
      nbytes       = 8'd0;
      tail_last    = 8'd0;
      tail_prev    = 8'd0;
      hdr_addr     = 8'd0;
      hdr_fn       = 8'd0;
      hdr_cnt      = 8'd0;
      echo_bad     = 1'b0;
    endfunction

    function logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      r = acc ^ {8'h00, data};
      repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? CRC_REV_POLY : 16'h0000);
      return r;
    endfunction

    function logic fn_reads_data(input logic [7:0] f);
      return f == FN_READ_COILS || f == FN_READ_DISCRETE || f == FN_READ_HOLDING ||
             f == FN_READ_INPUT || f == FN_READ_WRITE_REGS;
    endfunction

    function logic fn_echoes(input logic [7:0] f);
      return f == FN_WRITE_COIL || f == FN_WRITE_REG || f == FN_WRITE_COILS ||
             f == FN_WRITE_REGS;
    endfunction

    // Query byte that a write reply must repeat at frame positions two to five.
    function logic [7:0] echo_expect(input logic [7:0] pos);
      case (pos)
        8'd2:    return echo_addr[15:8];
        8'd3:    return echo_addr[7:0];
        8'd4:    return echo_val[15:8];
        default: return echo_val[7:0];
      endcase
    endfunction

    function void set_reg(input reg_idx_e idx, input logic [31:0] value);
      case (idx)
        REG_SLAVE:      slave     = value[7:0];
        REG_FUNCTION:   func      = value[7:0];
        REG_WORDS:      words     = value[6:0];
        REG_ECHO_ADDR:  echo_addr = value[15:0];
        REG_ECHO_VALUE: echo_val  = value[15:0];
        REG_JOB_SLOT:   slot      = value[2:0];
        default: ;
      endcase
    endfunction

    function void add_payload(input logic [7:0] data, input logic [7:0] off);
      reply_word_t r;
      r        = '0;
      r.kind   = KIND_PAYLOAD;
      r.pbyte  = data;
      r.offset = off;
      r.length = nbytes;
      due_replies.push_back(r);
    endfunction

    // Work out what one accepted input word makes the block return.
    function void take_rx_word(input logic [7:0] data, input logic present,
                               input logic last);
      logic [7:0]  pos;
      logic [15:0] want_crc;
      logic [2:0]  st;
      logic [3:0]  code;
      logic [6:0]  packed_st;
      int unsigned idx;
      reply_word_t r;
      // Bytes past the longest frame are dropped without trace.
      if (present && nbytes < MAX_FRAME) begin
        pos          = nbytes;
        crc_two_back = crc_one_back;
        crc_one_back = crc_run;
        crc_run      = crc16_step(crc_run, data);
        tail_prev    = tail_last;
        tail_last    = data;
        if (pos == POS_ADDRESS) hdr_addr = data;
        if (pos == POS_FUNCTION) hdr_fn = data;
        if (pos == POS_COUNT) hdr_cnt = data;
        if (pos >= POS_COUNT && pos <= POS_ECHO_END && data != echo_expect(pos))
          echo_bad = 1'b1;
        nbytes = pos + 8'd1;
        // A byte on the end word never goes out as payload.
        if (!last && pos >= POS_COUNT && hdr_fn == func) begin
          if (fn_reads_data(func) && pos >= POS_DATA && (pos - POS_DATA) < hdr_cnt)
            add_payload(data, pos - POS_DATA);
          else if (func == FN_READ_EXC_STATUS && pos == POS_COUNT)
            add_payload(data, 8'd0);
        end
      end
      if (last) begin
        code     = 4'd0;
        want_crc = crc_two_back;
        if (nbytes < MIN_FRAME) begin
          st = ST_SHORT;
        end else if (hdr_addr != slave) begin
          st = ST_BAD;
        end else if (tail_last != want_crc[15:8] || tail_prev != want_crc[7:0]) begin
          st = ST_CRC;
        end else if (hdr_fn != func) begin
          if ((hdr_fn & FN_MASK) == func) begin
            st   = ST_EXC;
            code = hdr_cnt[3:0];
          end else begin
            st = ST_BAD;
          end
        end else if (fn_reads_data(func)) begin
          st = (hdr_cnt[7:1] != words) ? ST_BAD : ST_OK;
        end else if (fn_echoes(func)) begin
          // A write reply too short to hold the whole echo counts as a mismatch.
          st = (echo_bad || nbytes < MIN_ECHO_FRAME) ? ST_BAD : ST_OK;
        end else if (func == FN_READ_EXC_STATUS) begin
          st = ST_OK;
        end else begin
          st = ST_BAD;
        end
        idx       = slot % JOB_SLOTS;
        packed_st = {st, code};
        r         = '0;
        r.kind    = KIND_STATUS;
        r.status  = st;
        r.code    = code;
        r.changed = (hist[idx] != packed_st);
        r.length  = nbytes;
        hist[idx] = packed_st;
        due_replies.push_back(r);
        clear_frame();
      end
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at %0t ns, word %0d: %s", $time, nchecked, msg);
      errors++;
    endtask

    task field_check(input string name, input int unsigned got, input int unsigned want);
      if (got != want)
        report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Compare one returned word with the oldest one owed.
    task check_reply(input reply_word_t got);
      reply_word_t want;
      nchecked++;
      if (due_replies.size() == 0) begin
        report_mismatch("word returned while none was owed");
      end else begin
        want = due_replies.pop_front();
        field_check("kind", got.kind, want.kind);
        field_check("payload_byte", got.pbyte, want.pbyte);
        field_check("payload_offset", got.offset, want.offset);
        field_check("status", got.status, want.status);
        field_check("exception_code", got.code, want.code);
        field_check("status_changed", got.changed, want.changed);
        field_check("frame_length", got.length, want.length);
      end
    endtask
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i      = 8'h00;
  logic                byte_present_i = 1'b0;
  logic                frame_end_i    = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic                kind_o;
  logic [7:0]          payload_byte_o;
  logic [7:0]          payload_offset_o;
  logic [2:0]          status_o;
  logic [3:0]          exception_code_o;
  logic                status_changed_o;
  logic [7:0]          frame_length_o;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [PADDR_W-1:0]  paddr          = '0;
  logic [PDATA_W-1:0]  pwdata         = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  frame_scoreboard sb = new();
  rx_word_t        tx_words[$];
  logic [7:0]      frame_bytes[$];
  int unsigned     words_sent   = 0;
  int unsigned     tx_idle_pct  = 8;
  int unsigned     rx_stall_pct = 53;
  bit              hold_ask     = 1'b0;

  modbus_rtu_response_checker_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .byte_present_i   (byte_present_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .payload_offset_o (payload_offset_o),
    .status_o         (status_o),
    .exception_code_o (exception_code_o),
    .status_changed_o (status_changed_o),
    .frame_length_o   (frame_length_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch both channels; every accepted word goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.take_rx_word(rx_byte_i, byte_present_i, frame_end_i);
      if (out_valid_o && !out_stall_i)
        sb.check_reply('{kind_o, payload_byte_o, payload_offset_o, status_o,
                         exception_code_o, status_changed_o, frame_length_o});
    end
  end

  // Receiver: random stalls, and a long hold-off when asked for one.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_ask && hold_left == 0) begin
        hold_ask  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
      end
    end
  end

  // Offer every queued word in turn, idling at random between them.
  task automatic send_words();
    rx_word_t    w;
    int unsigned gap;
    while (tx_words.size() != 0) begin
      w   = tx_words.pop_front();
      gap = 0;
      while ($urandom_range(0, 99) < tx_idle_pct) gap++;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i     <= 1'b1;
      rx_byte_i      <= w.data;
      byte_present_i <= w.present;
      frame_end_i    <= w.last;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      if (w.present || w.last) words_sent++;
    end
  endtask

  // Wait until every owed word has come back, then let the block go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.due_replies.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Append the CRC of the frame built so far, low byte first.
  task automatic add_crc();
    logic [15:0] c;
    c = CRC_START;
    foreach (frame_bytes[i]) c = sb.crc16_step(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
  endtask

  // Turn the frame into input words; the end flag rides on the last byte or
  // on an empty word of its own. An empty frame is a plain timeout.
  task automatic push_frame(input bit end_alone, input int unsigned idle_pct);
    rx_word_t    w;
    int unsigned n;
    n = frame_bytes.size();
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < idle_pct)
        tx_words.push_back('{data: 8'($urandom_range(0, 255)), present: 1'b0, last: 1'b0});
      w.data    = frame_bytes[i];
      w.present = 1'b1;
      w.last    = !end_alone && (i == n - 1);
      tx_words.push_back(w);
    end
    if (end_alone || n == 0)
      tx_words.push_back('{data: 8'($urandom_range(0, 255)), present: 1'b0, last: 1'b1});
  endtask

  // Build one reply for the current settings: mostly well formed, the rest
  // carrying one fault each.
  task automatic make_reply();
    logic [7:0]  fn;
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    fn   = sb.func;
    pick = $urandom_range(0, 99);
    frame_bytes.delete();
    frame_bytes.push_back((pick < 8) ? sb.slave ^ 8'($urandom_range(1, 255)) : sb.slave);
    if (pick >= 8 && pick < 16 && !fn[7]) begin
      // Exception reply with its code byte.
      frame_bytes.push_back(fn | 8'h80);
      frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (pick >= 16 && pick < 22) begin
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      frame_bytes.push_back(fn);
      if (sb.fn_reads_data(fn)) begin
        n = {sb.words, 1'b0};
        if (pick >= 22 && pick < 30) n = $urandom_range(0, 9);
        frame_bytes.push_back(8'(n));
        k = n;
        if (pick >= 30 && pick < 34) k = $urandom_range(0, n + 2);
        repeat (k) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (sb.fn_echoes(fn)) begin
        frame_bytes.push_back(sb.echo_addr[15:8]);
        frame_bytes.push_back(sb.echo_addr[7:0]);
        frame_bytes.push_back(sb.echo_val[15:8]);
        frame_bytes.push_back(sb.echo_val[7:0]);
        if (pick >= 22 && pick < 30)
          frame_bytes[$urandom_range(2, 5)] ^= 8'(1 << $urandom_range(0, 7));
        if (pick >= 30 && pick < 34)
          while (frame_bytes.size() > 3) void'(frame_bytes.pop_back());
      end else if (fn == FN_READ_EXC_STATUS) begin
        frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    add_crc();
    // Faults applied to the finished frame: a flipped bit, a cut, or noise.
    if (pick >= 34 && pick < 40)
      frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
    if (pick >= 40 && pick < 45) begin
      k = $urandom_range(0, 4);
      while (frame_bytes.size() > k) void'(frame_bytes.pop_back());
    end
    if (pick >= 45 && pick < 48) begin
      frame_bytes.delete();
      repeat ($urandom_range(0, 10)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    push_frame($urandom_range(0, 1), (pick >= 90) ? 20 : 2);
  endtask

  // Write every register; the first batch of a phase takes the low extremes,
  // and one batch takes the high extremes with the longest reads.
  task automatic apply_setting(input int unsigned setting, input int unsigned phase);
    logic [7:0]  fn_pool [14];
    logic [7:0]  slave;
    logic [7:0]  fn;
    logic [6:0]  nwords;
    logic [15:0] ea;
    logic [15:0] ev;
    logic [2:0]  slot;
    fn_pool = '{FN_READ_COILS, FN_READ_DISCRETE, FN_READ_HOLDING, FN_READ_INPUT,
                FN_WRITE_COIL, FN_WRITE_REG, FN_READ_EXC_STATUS, FN_WRITE_COILS,
                FN_WRITE_REGS, FN_READ_WRITE_REGS, 8'h00, 8'hFF, 8'h80, 8'h42};
    if (setting == 0) begin
      slave  = 8'h00;
      fn     = FN_READ_COILS;
      nwords = 7'd0;
      ea     = 16'h0000;
      ev     = 16'h0000;
      slot   = 3'd0;
    end else if (setting == 1 && phase == 2) begin
      slave  = 8'hFF;
      fn     = FN_READ_WRITE_REGS;
      nwords = 7'd127;
      ea     = 16'hFFFF;
      ev     = 16'hFFFF;
      slot   = 3'd7;
    end else begin
      slave  = 8'($urandom_range(0, 255));
      fn     = fn_pool[$urandom_range(0, 13)];
      nwords = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(5, 20))
                                           : 7'($urandom_range(0, 4));
      ea     = 16'($urandom_range(0, 65535));
      ev     = 16'($urandom_range(0, 65535));
      slot   = 3'($urandom_range(0, 7));
    end
    apb_write(REG_SLAVE, 32'(slave));
    apb_write(REG_FUNCTION, 32'(fn));
    apb_write(REG_WORDS, 32'(nwords));
    apb_write(REG_ECHO_ADDR, 32'(ea));
    apb_write(REG_ECHO_VALUE, 32'(ev));
    apb_write(REG_JOB_SLOT, 32'(slot));
  endtask

  // Hand-picked frames against the reset settings, then a short write echo.
  task automatic run_directed();
    frame_bytes = '{8'h01, FN_READ_HOLDING, 8'h02, 8'hAA, 8'h55};
    add_crc();
    push_frame(1'b0, 0);
    // Timeout: an end word with no byte.
    frame_bytes.delete();
    push_frame(1'b0, 0);
    // A word with neither flag is ignored.
    tx_words.push_back('{data: 8'h5A, present: 1'b0, last: 1'b0});
    frame_bytes = '{8'h01, FN_READ_HOLDING | 8'h80, 8'h0B};
    add_crc();
    push_frame(1'b0, 0);
    // Short frame closed by a separate end word.
    frame_bytes = '{8'hFF, 8'h00};
    push_frame(1'b1, 0);
    send_words();
    settle();
    apb_write(REG_FUNCTION, 32'(FN_WRITE_REGS));
    apb_write(REG_ECHO_ADDR, 32'h0000_1234);
    apb_write(REG_ECHO_VALUE, 32'h0000_FFFF);
    // Write reply with a valid CRC but too short to hold the echo.
    frame_bytes = '{8'h01, FN_WRITE_REGS, 8'h12};
    add_crc();
    push_frame(1'b0, 0);
    send_words();
    settle();
  endtask

  initial begin : stimulus
    int unsigned setting;
    int unsigned phase_start;
    int unsigned nframes;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    // Sender idles lightly then heavily, receiver the other way, then neither.
    for (int unsigned phase = 0; phase < 3; phase++) begin
      tx_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 53 : 0;
      rx_stall_pct = (phase == 0) ? 53 : (phase == 1) ? 8 : 0;
      phase_start  = words_sent;
      setting      = 0;
      while (words_sent - phase_start < PHASE_WORDS) begin
        apply_setting(setting, phase);
        if (setting == 2) hold_ask = 1'b1;
        nframes = (sb.words > 7'd8) ? 2 : 10;
        repeat (nframes) make_reply();
        send_words();
        settle();
        setting++;
      end
    end
    if (sb.errors == 0 && sb.due_replies.size() == 0) begin
      $display("[modbus_rtu_response_checker_core] OK");
    end else begin
      $display("[modbus_rtu_response_checker_core] ERROR");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("[modbus_rtu_response_checker_core] ERROR");
    $finish;
  end

endmodule
